// ----- hdl/gbtm_pkg.sv -----
// Shared types and constants for the grid BSP tree map.
// Holds the request/response beat structs, CSR indexes and the FSM states.
// No dependencies.
package gbtm_pkg;

   localparam int COORD_W   = 6;
   localparam int VAL_W     = 32;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 2;

   localparam int MAX_DIM_DEF       = 64;
   localparam int NODE_CAPACITY_DEF = 8192;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;

   localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_SET = 1'b1;

   typedef struct packed {
      logic                    req_type;
      logic [COORD_W-1:0]      cell_x;
      logic [COORD_W-1:0]      cell_y;
      logic signed [VAL_W-1:0] start_in;
      logic signed [VAL_W-1:0] end_in;
   } gbtm_req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] start_out;
      logic signed [VAL_W-1:0] end_out;
      logic                    full_res;
   } gbtm_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_FRESH,
      ST_LEAF,
      ST_LEAF_NEW
   } gbtm_state_type;

endpackage

// ----- hdl/gbtm_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module gbtm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/grid_bsp_tree_map_core.sv -----
// Top level of the grid BSP tree map: walk FSM, split geometry and CSRs.
// Depends on gbtm_pkg and gbtm_ram (two instances, one per node word).
//
// Use: a request beat (get or set of one grid cell) is taken when start is
// high and busy is low. The walk descends the tree one level per cycle: the
// node pair is read from the two word RAMs, the split is decided and the
// child read is issued in the same cycle. Absent children are allocated on
// the way; once a fresh node is made, every level below it is written
// without a read. The leaf state then writes or reads the cell and raises
// the response. busy falls in the strobe cycle, so a new request may be
// taken then; one request is in flight at a time.
// The response is a one-cycle strobe; the receiver cannot stall it.
// CSR writes (grid width, height) are always ready and take effect on the
// next request; write only while idle.
// Reset: sizes return to 64 x 64, the free-node counter to 1 and the root
// pair reads as zero. No memory clearing pass is needed.
module grid_bsp_tree_map_core #(
   parameter int MAX_DIM       = gbtm_pkg::MAX_DIM_DEF,
   parameter int NODE_CAPACITY = gbtm_pkg::NODE_CAPACITY_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  gbtm_pkg::gbtm_req_type           req_data,
   output logic                             rsp_valid,
   output gbtm_pkg::gbtm_rsp_type           rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gbtm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gbtm_pkg::CFG_W-1:0]       csr_data
);

   import gbtm_pkg::*;

   localparam int NODE_W = $clog2(NODE_CAPACITY);
   localparam int NF_W   = $clog2(NODE_CAPACITY + 1);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int CMP_W  = (DIM_W > COORD_W) ? DIM_W : COORD_W;
   localparam int CLW    = (DIM_W > CFG_W) ? DIM_W : CFG_W;

   localparam logic [CLW-1:0]   MAX_DIM_C = CLW'(MAX_DIM);
   localparam logic [VAL_W-1:0] CAP_C     = VAL_W'(NODE_CAPACITY);
   localparam logic [NF_W-1:0]  CAP_NF    = NF_W'(NODE_CAPACITY);

   gbtm_state_type       state_ff, state_in;
   logic [NODE_W-1:0]    node_ff, node_in;
   logic [DIM_W-1:0]     sx_ff, sx_in, sy_ff, sy_in, ox_ff, ox_in, oy_ff, oy_in;
   logic [NF_W-1:0]      nf_ff, nf_in;
   gbtm_req_type         req_ff, req_in;
   logic [1:0]           root_v_ff, root_v_in;
   logic [CFG_W-1:0]     gw_ff, gh_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   gbtm_rsp_type         rsp_data_ff, rsp_data_in;

   logic                 rd_en;
   logic [NODE_W-1:0]    rd_addr;
   logic                 wr0_en, wr1_en;
   logic [NODE_W-1:0]    wr0_addr, wr1_addr;
   logic [VAL_W-1:0]     wr0_data, wr1_data;
   logic [VAL_W-1:0]     q0, q1, q0m, q1m;

   logic [DIM_W-1:0]     init_sx, init_sy;
   logic                 init_done;
   logic [CLW-1:0]       gw_ext, gh_ext;

   logic                 axis_x, go_left, split_done;
   logic [DIM_W-1:0]     lo, base, nsx, nsy, nox, noy;
   logic [CMP_W-1:0]     coord_c, bound_c;
   logic [VAL_W-1:0]     slot_word;
   logic                 child_ok, mem_full, accept;
   logic [VAL_W-1:0]     nf_word;

   // ---------------------------------------------------------------- CSRs
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff <= GRID_RESET;
         gh_ff <= GRID_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRID_WIDTH:  gw_ff <= csr_data;
            CSR_GRID_HEIGHT: gh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // size clamp: zero reads as one, oversize as MAX_DIM
   always_comb begin
      gw_ext = CLW'(gw_ff);
      gh_ext = CLW'(gh_ff);
      if (gw_ff == '0) begin
         init_sx = DIM_W'(1);
      end else if (gw_ext > MAX_DIM_C) begin
         init_sx = DIM_W'(MAX_DIM);
      end else begin
         init_sx = gw_ext[DIM_W-1:0];
      end
      if (gh_ff == '0) begin
         init_sy = DIM_W'(1);
      end else if (gh_ext > MAX_DIM_C) begin
         init_sy = DIM_W'(MAX_DIM);
      end else begin
         init_sy = gh_ext[DIM_W-1:0];
      end
      init_done = (init_sx <= DIM_W'(1)) && (init_sy <= DIM_W'(1));
   end

   // ---------------------------------------------------------------- node RAMs
   gbtm_ram #(.WIDTH(VAL_W), .DEPTH(NODE_CAPACITY)) u_word0 (
      .clock   (clock),
      .wr_en   (wr0_en),
      .wr_addr (wr0_addr),
      .wr_data (wr0_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (q0)
   );

   gbtm_ram #(.WIDTH(VAL_W), .DEPTH(NODE_CAPACITY)) u_word1 (
      .clock   (clock),
      .wr_en   (wr1_en),
      .wr_addr (wr1_addr),
      .wr_data (wr1_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (q1)
   );

   // root words read as zero until first written
   assign q0m = (node_ff == '0 && !root_v_ff[0]) ? '0 : q0;
   assign q1m = (node_ff == '0 && !root_v_ff[1]) ? '0 : q1;

   // ---------------------------------------------------------------- split
   always_comb begin
      axis_x  = sx_ff > sy_ff;
      lo      = (axis_x ? sx_ff : sy_ff) >> 1;
      base    = (axis_x ? ox_ff : oy_ff) + lo;
      coord_c = axis_x ? CMP_W'(req_ff.cell_x) : CMP_W'(req_ff.cell_y);
      bound_c = CMP_W'(base);
      go_left = coord_c < bound_c;
      nsx = sx_ff;
      nsy = sy_ff;
      nox = ox_ff;
      noy = oy_ff;
      if (axis_x) begin
         if (go_left) begin
            nsx = lo;
         end else begin
            nox = base;
            nsx = sx_ff - lo;
         end
      end else begin
         if (go_left) begin
            nsy = lo;
         end else begin
            noy = base;
            nsy = sy_ff - lo;
         end
      end
      split_done = (nsx <= DIM_W'(1)) && (nsy <= DIM_W'(1));
   end

   assign slot_word = go_left ? q0m : q1m;
   assign child_ok  = (slot_word != '0) && (slot_word < CAP_C);
   assign mem_full  = nf_ff >= CAP_NF;
   assign nf_word   = VAL_W'(nf_ff);
   assign accept    = start && !busy;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = init_done ? ST_LEAF : ST_WALK;
            end
         end
         ST_WALK: begin
            if (child_ok) begin
               state_in = split_done ? ST_LEAF : ST_WALK;
            end else if (mem_full) begin
               state_in = ST_IDLE;
            end else begin
               state_in = split_done ? ST_LEAF_NEW : ST_FRESH;
            end
         end
         ST_FRESH: begin
            if (mem_full) begin
               state_in = ST_IDLE;
            end else begin
               state_in = split_done ? ST_LEAF_NEW : ST_FRESH;
            end
         end
         ST_LEAF:     state_in = ST_IDLE;
         ST_LEAF_NEW: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      node_in      = node_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      nf_in        = nf_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = node_ff;
      wr0_en       = 1'b0;
      wr1_en       = 1'b0;
      wr0_addr     = node_ff;
      wr1_addr     = node_ff;
      wr0_data     = '0;
      wr1_data     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in  = req_data;
               sx_in   = init_sx;
               sy_in   = init_sy;
               ox_in   = '0;
               oy_in   = '0;
               node_in = '0;
               rd_en   = 1'b1;
               rd_addr = '0;
            end
         end
         ST_WALK: begin
            if (child_ok) begin
               rd_en   = 1'b1;
               rd_addr = slot_word[NODE_W-1:0];
               node_in = slot_word[NODE_W-1:0];
               sx_in = nsx;
               sy_in = nsy;
               ox_in = nox;
               oy_in = noy;
            end else if (mem_full) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{start_out: '0, end_out: '0, full_res: 1'b1};
            end else begin
               // link the new child into the parent's slot
               wr0_en   = go_left;
               wr1_en   = !go_left;
               wr0_data = nf_word;
               wr1_data = nf_word;
               node_in  = nf_ff[NODE_W-1:0];
               nf_in    = nf_ff + 1'b1;
               sx_in = nsx;
               sy_in = nsy;
               ox_in = nox;
               oy_in = noy;
            end
         end
         ST_FRESH: begin
            wr0_en = 1'b1;
            wr1_en = 1'b1;
            if (mem_full) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{start_out: '0, end_out: '0, full_res: 1'b1};
            end else begin
               // zero the fresh node and link its child in the same write
               wr0_data = go_left ? nf_word : '0;
               wr1_data = go_left ? '0 : nf_word;
               node_in  = nf_ff[NODE_W-1:0];
               nf_in    = nf_ff + 1'b1;
               sx_in = nsx;
               sy_in = nsy;
               ox_in = nox;
               oy_in = noy;
            end
         end
         ST_LEAF: begin
            rsp_valid_in = 1'b1;
            if (req_ff.req_type == REQ_SET) begin
               wr0_en   = 1'b1;
               wr1_en   = 1'b1;
               wr0_data = req_ff.start_in;
               wr1_data = req_ff.end_in;
               rsp_data_in = '{start_out: req_ff.start_in, end_out: req_ff.end_in,
                               full_res: 1'b0};
            end else begin
               rsp_data_in = '{start_out: q0m, end_out: q1m, full_res: 1'b0};
            end
         end
         ST_LEAF_NEW: begin
            rsp_valid_in = 1'b1;
            wr0_en = 1'b1;
            wr1_en = 1'b1;
            if (req_ff.req_type == REQ_SET) begin
               wr0_data = req_ff.start_in;
               wr1_data = req_ff.end_in;
               rsp_data_in = '{start_out: req_ff.start_in, end_out: req_ff.end_in,
                               full_res: 1'b0};
            end else begin
               rsp_data_in = '{start_out: '0, end_out: '0, full_res: 1'b0};
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      root_v_in = root_v_ff;
      if (wr0_en && wr0_addr == '0) begin
         root_v_in[0] = 1'b1;
      end
      if (wr1_en && wr1_addr == '0) begin
         root_v_in[1] = 1'b1;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nf_ff        <= NF_W'(1);
         root_v_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nf_ff        <= nf_in;
         root_v_ff    <= root_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff != ST_IDLE))
      else $error("response strobe without a walk in progress");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(wr0_en || wr1_en))
      else $error("node RAM written while idle");

   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !(wr0_en || wr1_en))
      else $error("node RAM read and write in the same cycle");

   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && nf_ff != $past(nf_ff)) |-> (nf_ff == $past(nf_ff) + NF_W'(1)))
      else $error("free-node counter moved by more than one");

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      (nf_ff != $past(nf_ff) && !$past(reset)) |-> ($past(nf_ff) < CAP_NF))
      else $error("node allocated beyond capacity");
`endif

endmodule
